// ===== sv/oate_pkg.sv =====
package oate_pkg;

  localparam int unsigned DEPTH_DEF      = 128;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FILL_W   = 8;

  // stream payload widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 48;
  localparam int unsigned M_USED_W  = STATUS_W + VALUE_W + FILL_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_READ    = 2'd2,
    CMD_REVERSE = 2'd3
  } oate_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } oate_status_e;

  // controller to datapath
  typedef struct packed {
    logic         accept;     // latch position and value
    logic         srch_start; // walk index to zero
    logic         ins_start;  // walk index to last entry
    logic         del_start;  // walk index to entry above the hit
    logic         idx_inc;
    logic         idx_dec;
    logic         chk;        // search read at walk index
    logic         shift_rd;   // shift read at walk index, write follows
    logic         shift_up;   // shift direction for insert
    logic         rd_pos;     // read at position
    logic         put_value;  // write value at position
    logic         rv_init;
    logic         rv_rd;      // read both ends
    logic         rv_wlo;
    logic         rv_whi;
    logic         cnt_inc;
    logic         cnt_dec;
    logic         res_load;
    logic         res_rd;
    oate_status_e res_status;
  } oate_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic cnt_full;
    logic cnt_zero;
    logic cnt_gt1;
    logic idx_eq_cnt;
    logic idx_at_pos;
    logic idx_last;
    logic chk_vld;
    logic hit;
    logic hit_last;
    logic rv_more;
  } oate_stat_t;

endpackage

// ===== sv/ordered_array_table_engine.sv =====
// ordered array of signed words with a fill count, one command per input
// transfer and exactly one result transfer per command. commands: insert
// a value at a position (later entries move up), delete the first entry
// equal to a key (later entries move down), read the entry at a position,
// reverse the filled part. status reports a bad position, an empty array,
// a missing key or an insert into a full array; a failed command leaves
// the array untouched. entries live in a ram with one write port and two
// registered read ports, so insert, delete and reverse walk through the
// ram and write the moved entries one at a time. one command is worked
// on at a time; a new command is taken while the previous result still
// sits in the output register. no clearing pass after reset: only
// entries below the fill count are ever read
module ordered_array_table_engine import oate_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,      // entries, 2 to 255
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF  // stored bits, 1 to 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // position [7:0], value [39:8]
  input  logic [CMD_W-1:0]     s_axis_tuser,  // command [1:0]
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata   // status [2:0], read_data [34:3],
                                              // fill_count [42:35], zero [47:43]
);

  oate_ctrl_t         ctrl;
  oate_stat_t         stat;
  oate_status_e       res_status;
  logic [VALUE_W-1:0] res_rdata;
  logic [FILL_W-1:0]  res_fill;

  // sequencing: decode, walk, result hand-off
  oate_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .ctrl_o      (ctrl),
    .stat_i      (stat)
  );

  // entry ram, count, walk pointers and the result register
  oate_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_pos_i     (s_axis_tdata[POS_W-1:0]),
    .in_value_i   (s_axis_tdata[POS_W+VALUE_W-1:POS_W]),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .res_status_o (res_status),
    .res_rdata_o  (res_rdata),
    .res_fill_o   (res_fill)
  );

  // pack the result, first field in the lowest bits
  assign m_axis_tdata = {{(M_TDATA_W - M_USED_W){1'b0}}, res_fill, res_rdata, res_status};

  // the ram write port has one source at a time
  a_one_writer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl.put_value, ctrl.rv_wlo, ctrl.rv_whi}))
    else $error("more than one ram write source");

  // a result is loaded only when the output register is free or draining
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.res_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before transfer");

  // a failed command carries zero read data
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_status != ST_OK) |-> (res_rdata == '0))
    else $error("failed command with nonzero read data");

  // full is only reported with the array at capacity
  a_full_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_status == ST_FULL) |-> (res_fill == FILL_W'(DEPTH)))
    else $error("full status with array below capacity");

endmodule

// ===== sv/oate_ram.sv =====
module oate_ram import oate_pkg::*; #(
  parameter int unsigned WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_a_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic             re_b_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== sv/oate_dp.sv =====
module oate_dp import oate_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [POS_W-1:0]   in_pos_i,
  input  logic [VALUE_W-1:0] in_value_i,
  input  oate_ctrl_t         ctrl_i,
  output oate_stat_t         stat_o,
  output oate_status_e       res_status_o,
  output logic [VALUE_W-1:0] res_rdata_o,
  output logic [FILL_W-1:0]  res_fill_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned PCW  = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned EXTW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [POS_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] key_q;
  logic                  chk_vld_q;
  logic [AW-1:0]         chk_addr_q;
  logic                  pend_q;
  logic [AW-1:0]         pend_addr_q;
  logic [AW-1:0]         lo_q, lo_d;
  logic [AW-1:0]         hi_q, hi_d;
  oate_status_e          res_status_q;
  logic [VALUE_W-1:0]    res_rdata_q;
  logic [FILL_W-1:0]     res_fill_q;

  logic signed [EXTW-1:0] val_ext;
  logic signed [EXTW-1:0] rd_ext;
  logic [PCW-1:0]         pos_x;
  logic [PCW-1:0]         cnt_x;
  logic [AW-1:0]          idx_a;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  re_a;
  logic [AW-1:0]         raddr_a;
  logic [DATA_WIDTH-1:0] rdata_a;
  logic                  re_b;
  logic [AW-1:0]         raddr_b;
  logic [DATA_WIDTH-1:0] rdata_b;

  assign val_ext = EXTW'($signed(in_value_i));
  assign rd_ext  = EXTW'($signed(rdata_a));
  assign pos_x   = PCW'(pos_q);
  assign cnt_x   = PCW'(cnt_q);
  assign idx_a   = idx_q[AW-1:0];

  // flags for the controller
  assign stat_o.pos_gt_cnt = pos_x > cnt_x;
  assign stat_o.pos_ge_cnt = pos_x >= cnt_x;
  assign stat_o.cnt_full   = cnt_q == CW'(DEPTH);
  assign stat_o.cnt_zero   = cnt_q == '0;
  assign stat_o.cnt_gt1    = cnt_q > CW'(1);
  assign stat_o.idx_eq_cnt = idx_q == cnt_q;
  assign stat_o.idx_at_pos = PCW'(idx_q) == pos_x;
  assign stat_o.idx_last   = (idx_q + CW'(1)) == cnt_q;
  assign stat_o.chk_vld    = chk_vld_q;
  assign stat_o.hit        = chk_vld_q && (rdata_a == key_q);
  assign stat_o.hit_last   = (CW'(chk_addr_q) + CW'(1)) == cnt_q;
  assign stat_o.rv_more    = (CW'(lo_q) + CW'(1)) < CW'(hi_q);

  // memory ports
  assign re_a    = ctrl_i.chk | ctrl_i.shift_rd | ctrl_i.rd_pos | ctrl_i.rv_rd;
  assign raddr_a = ctrl_i.rd_pos ? pos_x[AW-1:0] : (ctrl_i.rv_rd ? lo_q : idx_a);
  assign re_b    = ctrl_i.rv_rd;
  assign raddr_b = ctrl_i.rv_whi ? (hi_q - AW'(1)) : hi_q;

  always_comb begin
    we    = 1'b1;
    waddr = pend_addr_q;
    wdata = rdata_a;
    if (pend_q) begin
      waddr = pend_addr_q;
      wdata = rdata_a;
    end else if (ctrl_i.put_value) begin
      waddr = pos_x[AW-1:0];
      wdata = key_q;
    end else if (ctrl_i.rv_wlo) begin
      waddr = lo_q;
      wdata = rdata_b;
    end else if (ctrl_i.rv_whi) begin
      waddr = hi_q;
      wdata = rdata_a;
    end else begin
      we = 1'b0;
    end
  end

  oate_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_a_i    (re_a),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .re_b_i    (re_b),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (ctrl_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end

    idx_d = idx_q;
    if (ctrl_i.srch_start) begin
      idx_d = '0;
    end else if (ctrl_i.ins_start) begin
      idx_d = cnt_q - CW'(1);
    end else if (ctrl_i.del_start) begin
      idx_d = CW'(chk_addr_q) + CW'(1);
    end else if (ctrl_i.idx_inc) begin
      idx_d = idx_q + CW'(1);
    end else if (ctrl_i.idx_dec) begin
      idx_d = idx_q - CW'(1);
    end

    lo_d = lo_q;
    hi_d = hi_q;
    if (ctrl_i.rv_init) begin
      lo_d = '0;
      hi_d = AW'(cnt_q - CW'(1));
    end else if (ctrl_i.rv_wlo) begin
      lo_d = lo_q + AW'(1);
    end else if (ctrl_i.rv_whi) begin
      hi_d = hi_q - AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      chk_vld_q <= ctrl_i.chk;
      pend_q    <= ctrl_i.shift_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    if (ctrl_i.accept) begin
      pos_q <= in_pos_i;
      key_q <= val_ext[DATA_WIDTH-1:0];
    end
    if (ctrl_i.chk) begin
      chk_addr_q <= idx_a;
    end
    if (ctrl_i.shift_rd) begin
      pend_addr_q <= ctrl_i.shift_up ? (idx_a + AW'(1)) : (idx_a - AW'(1));
    end
    if (ctrl_i.res_load) begin
      res_status_q <= ctrl_i.res_status;
      res_rdata_q  <= ctrl_i.res_rd ? rd_ext[VALUE_W-1:0] : '0;
      res_fill_q   <= FILL_W'(cnt_q);
    end
  end

  assign res_status_o = res_status_q;
  assign res_rdata_o  = res_rdata_q;
  assign res_fill_o   = res_fill_q;

endmodule

// ===== sv/oate_ctrl.sv =====
module oate_ctrl import oate_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] in_cmd_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output oate_ctrl_t       ctrl_o,
  input  oate_stat_t       stat_i
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_INS_SHIFT = 4'd2;
  localparam logic [3:0] S_DRAIN     = 4'd3;
  localparam logic [3:0] S_INS_PUT   = 4'd4;
  localparam logic [3:0] S_DEL_SRCH  = 4'd5;
  localparam logic [3:0] S_DEL_SHIFT = 4'd6;
  localparam logic [3:0] S_RV_RD     = 4'd7;
  localparam logic [3:0] S_RV_WLO    = 4'd8;
  localparam logic [3:0] S_RV_WHI    = 4'd9;
  localparam logic [3:0] S_DONE      = 4'd10;

  logic [3:0]   state_q, state_d;
  oate_cmd_e    op_q, op_d;
  oate_status_e code_q, code_d;
  logic         out_vld_q, out_vld_d;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    code_d    = code_q;
    out_vld_d = out_vld_q;
    ctrl_o    = '0;

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.accept = 1'b1;
          op_d          = oate_cmd_e'(in_cmd_i);
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        code_d = ST_OK;
        case (op_q)
          CMD_INSERT: begin
            if (stat_i.pos_gt_cnt) begin
              code_d  = ST_BADPOS;
              state_d = S_DONE;
            end else if (stat_i.cnt_full) begin
              code_d  = ST_FULL;
              state_d = S_DONE;
            end else if (stat_i.pos_ge_cnt) begin
              state_d = S_INS_PUT;
            end else begin
              ctrl_o.ins_start = 1'b1;
              state_d          = S_INS_SHIFT;
            end
          end
          CMD_DELETE: begin
            if (stat_i.cnt_zero) begin
              code_d  = ST_EMPTY;
              state_d = S_DONE;
            end else begin
              ctrl_o.srch_start = 1'b1;
              state_d           = S_DEL_SRCH;
            end
          end
          CMD_READ: begin
            if (stat_i.pos_ge_cnt) begin
              code_d = ST_BADPOS;
            end else begin
              ctrl_o.rd_pos = 1'b1;
            end
            state_d = S_DONE;
          end
          default: begin
            if (stat_i.cnt_gt1) begin
              ctrl_o.rv_init = 1'b1;
              state_d        = S_RV_RD;
            end else begin
              state_d = S_DONE;
            end
          end
        endcase
      end
      S_INS_SHIFT: begin
        ctrl_o.shift_rd = 1'b1;
        ctrl_o.shift_up = 1'b1;
        ctrl_o.idx_dec  = 1'b1;
        if (stat_i.idx_at_pos) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (op_q == CMD_INSERT) begin
          state_d = S_INS_PUT;
        end else begin
          ctrl_o.cnt_dec = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_INS_PUT: begin
        ctrl_o.put_value = 1'b1;
        ctrl_o.cnt_inc   = 1'b1;
        state_d          = S_DONE;
      end
      S_DEL_SRCH: begin
        if (stat_i.hit) begin
          if (stat_i.hit_last) begin
            ctrl_o.cnt_dec = 1'b1;
            state_d        = S_DONE;
          end else begin
            ctrl_o.del_start = 1'b1;
            state_d          = S_DEL_SHIFT;
          end
        end else if (!stat_i.idx_eq_cnt) begin
          ctrl_o.chk     = 1'b1;
          ctrl_o.idx_inc = 1'b1;
        end else if (!stat_i.chk_vld) begin
          code_d  = ST_NOTFOUND;
          state_d = S_DONE;
        end
      end
      S_DEL_SHIFT: begin
        ctrl_o.shift_rd = 1'b1;
        ctrl_o.idx_inc  = 1'b1;
        if (stat_i.idx_last) begin
          state_d = S_DRAIN;
        end
      end
      S_RV_RD: begin
        ctrl_o.rv_rd = 1'b1;
        state_d      = S_RV_WLO;
      end
      S_RV_WLO: begin
        ctrl_o.rv_wlo = 1'b1;
        state_d       = S_RV_WHI;
      end
      S_RV_WHI: begin
        ctrl_o.rv_whi = 1'b1;
        if (stat_i.rv_more) begin
          ctrl_o.rv_rd = 1'b1;
          state_d      = S_RV_WLO;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          ctrl_o.res_load   = 1'b1;
          ctrl_o.res_status = code_q;
          ctrl_o.res_rd     = (op_q == CMD_READ) && (code_q == ST_OK);
          out_vld_d         = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    code_q <= code_d;
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_vld_q;

endmodule

// ===== tb/oate_table_checker.sv =====
module oate_table_checker import oate_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic [CMD_W-1:0]     s_tuser_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [M_TDATA_W-1:0] m_tdata_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   fill_level_o,
  output int                   checked_o,
  output int                   peak_fill_o,
  output int                   full_hits_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RD_LSB   = STATUS_W;
  localparam int unsigned FILL_LSB = STATUS_W + VALUE_W;

  typedef struct packed {
    oate_status_e         status;
    logic [VALUE_W-1:0]   read_data;
    logic [FILL_W-1:0]    fill;
  } table_result_t;

  logic [VALUE_W-1:0] table_words [DEPTH];
  int unsigned        table_used;
  table_result_t      awaited_results [$];

  // mirror of the array, one command at a time
  task automatic apply_table_command(input oate_cmd_e cmd, input logic [POS_W-1:0] pos,
                                     input logic [VALUE_W-1:0] val,
                                     output table_result_t res);
    int unsigned        hit;
    int unsigned        lo;
    int unsigned        hi;
    logic [VALUE_W-1:0] swap;
    res.status    = ST_OK;
    res.read_data = '0;
    case (cmd)
      CMD_INSERT: begin
        // bad position is checked before full
        if (pos > table_used) res.status = ST_BADPOS;
        else if (table_used == DEPTH) res.status = ST_FULL;
        else begin
          for (int unsigned i = table_used; i > pos; i--) table_words[i] = table_words[i-1];
          table_words[pos] = val;
          table_used++;
        end
      end
      CMD_DELETE: begin
        if (table_used == 0) res.status = ST_EMPTY;
        else begin
          hit = table_used;
          for (int unsigned i = 0; i < table_used; i++) begin
            if (table_words[i] == val) begin
              hit = i;
              break;
            end
          end
          if (hit == table_used) res.status = ST_NOTFOUND;
          else begin
            for (int unsigned i = hit; i + 1 < table_used; i++) table_words[i] = table_words[i+1];
            table_used--;
          end
        end
      end
      CMD_READ: begin
        if (pos >= table_used) res.status = ST_BADPOS;
        else res.read_data = table_words[pos];
      end
      default: begin
        if (table_used > 1) begin
          lo = 0;
          hi = table_used - 1;
          while (lo < hi) begin
            swap            = table_words[lo];
            table_words[lo] = table_words[hi];
            table_words[hi] = swap;
            lo++;
            hi--;
          end
        end
      end
    endcase
    res.fill = FILL_W'(table_used);
  endtask

  always @(posedge clk_i) begin : watch
    table_result_t seen;
    table_result_t want;
    if (!rst_ni) begin
      table_used   = 0;
      awaited_results.delete();
      fail_count_o = 0;
      checked_o    = 0;
      peak_fill_o  = 0;
      full_hits_o  = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        seen.status    = oate_status_e'(m_tdata_i[STATUS_W-1:0]);
        seen.read_data = m_tdata_i[RD_LSB +: VALUE_W];
        seen.fill      = m_tdata_i[FILL_LSB +: FILL_W];
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing outstanding: status %0d read_data %0h fill %0d",
                 seen.status, seen.read_data, seen.fill);
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          if (seen.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, seen.status);
            fail_count_o++;
          end
          if (seen.read_data != want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, seen.read_data);
            fail_count_o++;
          end
          if (seen.fill != want.fill) begin
            $error("fill_count: expected %0d, got %0d", want.fill, seen.fill);
            fail_count_o++;
          end
          checked_o++;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        apply_table_command(oate_cmd_e'(s_tuser_i), s_tdata_i[POS_W-1:0],
                            s_tdata_i[POS_W +: VALUE_W], want);
        awaited_results.push_back(want);
        if (want.status == ST_FULL) full_hits_o++;
      end
    end
    pending_o    = awaited_results.size();
    fill_level_o = table_used;
    if (fill_level_o > peak_fill_o) peak_fill_o = fill_level_o;
  end

endmodule

// ===== tb/tb.sv =====
module tb;

  import oate_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1250;
  localparam int TAIL_CYCLES  = 300;   // worst walk grows with DEPTH

  // command mixes for the random blocks
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} cmd_mix_e;
  // receiver stall patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BUSY} rx_pattern_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // position [7:0], value [39:8]
  logic [CMD_W-1:0]     s_axis_tuser;   // command [1:0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // status [2:0], read_data [34:3], fill_count [42:35]

  int fail_count;
  int pending;
  int fill_level;
  int checked;
  int peak_fill;
  int full_hits;

  // sender bookkeeping
  int                 sent;
  int                 burst_left;
  bit                 offering;
  logic [VALUE_W-1:0] key_pool [$];   // recent inserted values, used as delete keys

  ordered_array_table_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  oate_table_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .fill_level_o (fill_level),
    .checked_o    (checked),
    .peak_fill_o  (peak_fill),
    .full_hits_o  (full_hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // offer one command and hold it until the transfer; then maybe a gap
  task automatic send_cmd(input oate_cmd_e cmd, input logic [POS_W-1:0] pos,
                          input logic [VALUE_W-1:0] val);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {val, pos};
    offering = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    if (cmd == CMD_INSERT) begin
      key_pool.push_back(val);
      if (key_pool.size() > 32) void'(key_pool.pop_front());
    end
    @(negedge clk_i);
    // bursts of back-to-back transfers, random gaps between them
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap        = $urandom_range(1, 16);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // stop offering and wait until every result has been seen
  task automatic drain();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
    while (pending != 0) @(negedge clk_i);
  endtask

  // extremes, recent values for duplicates, otherwise anything
  function automatic logic [VALUE_W-1:0] next_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    if (r < 3 && key_pool.size() > 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return $urandom;
  endfunction

  // mostly keys that were inserted lately, some that never were
  function automatic logic [VALUE_W-1:0] next_key();
    if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] insert_pos();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 8) return POS_W'($urandom_range(0, fill_level));
    if (r == 8) return POS_W'(fill_level);
    return POS_W'($urandom_range(fill_level + 1, 255));   // past the end
  endfunction

  function automatic logic [POS_W-1:0] read_pos();
    if (fill_level > 0 && $urandom_range(0, 9) < 8)
      return POS_W'($urandom_range(0, fill_level - 1));
    return POS_W'($urandom_range(0, 255));
  endfunction

  function automatic oate_cmd_e pick_cmd(input cmd_mix_e mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 70) return CMD_INSERT;
        if (r < 80) return CMD_DELETE;
        if (r < 95) return CMD_READ;
        return CMD_REVERSE;
      end
      MIX_SHRINK: begin
        if (r < 15) return CMD_INSERT;
        if (r < 75) return CMD_DELETE;
        if (r < 95) return CMD_READ;
        return CMD_REVERSE;
      end
      default: begin
        if (r < 30) return CMD_INSERT;
        if (r < 60) return CMD_DELETE;
        if (r < 90) return CMD_READ;
        return CMD_REVERSE;
      end
    endcase
  endfunction

  task automatic random_cmd(input cmd_mix_e mix);
    oate_cmd_e cmd;
    cmd = pick_cmd(mix);
    case (cmd)
      CMD_INSERT: send_cmd(cmd, insert_pos(), next_value());
      CMD_DELETE: send_cmd(cmd, POS_W'($urandom_range(0, 255)), next_key());
      CMD_READ:   send_cmd(cmd, read_pos(), $urandom);
      default:    send_cmd(cmd, POS_W'($urandom_range(0, 255)), $urandom);
    endcase
  endtask

  // fill the array to the top, poke the full and past-the-end cases, reverse it
  task automatic fill_up();
    while (fill_level < DEPTH_DEF) send_cmd(CMD_INSERT, POS_W'($urandom_range(0, fill_level)),
                                            next_value());
    send_cmd(CMD_INSERT, 8'd0, next_value());
    send_cmd(CMD_INSERT, POS_W'(DEPTH_DEF), next_value());       // at the end, still full
    send_cmd(CMD_INSERT, POS_W'(DEPTH_DEF + 1), next_value());   // past the end wins over full
    send_cmd(CMD_INSERT, 8'd255, next_value());
    send_cmd(CMD_READ, POS_W'(DEPTH_DEF - 1), $urandom);
    send_cmd(CMD_READ, POS_W'(DEPTH_DEF), $urandom);
    send_cmd(CMD_REVERSE, 8'd0, $urandom);
    send_cmd(CMD_READ, 8'd0, $urandom);
    send_cmd(CMD_READ, POS_W'(DEPTH_DEF - 1), $urandom);
  endtask

  // receiver: own stall pattern, plus one long hold-off so the block backs up
  initial begin : receiver
    int          cyc;
    int          stretch;
    int          hold_left;
    bit          held;
    rx_pattern_e pattern;
    m_axis_tready = 1'b0;
    cyc       = 0;
    stretch   = 0;
    hold_left = 0;
    held      = 1'b0;
    pattern   = RX_OPEN;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (!held && cyc >= 3000 && s_axis_tvalid) begin
        held      = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (stretch == 0) begin
          stretch = $urandom_range(20, 200);
          pattern = rx_pattern_e'($urandom_range(0, 3));
        end
        stretch--;
        case (pattern)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // sender and verdict
  initial begin : stimulus
    int       fills_done;
    bit       paused;
    int       block_len;
    cmd_mix_e mix;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_READ;
    sent          = 0;
    burst_left    = 0;
    offering      = 1'b0;
    fills_done    = 0;
    paused        = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty array: read, delete and reverse, insert past the end
    send_cmd(CMD_READ, 8'd0, 32'h0000_0000);
    send_cmd(CMD_DELETE, 8'd0, 32'h0000_0005);
    send_cmd(CMD_REVERSE, 8'd0, 32'h0000_0000);
    send_cmd(CMD_INSERT, 8'd1, 32'h1234_5678);
    // single entry, then grow at the end, the front and the middle
    send_cmd(CMD_INSERT, 8'd0, 32'h7fff_ffff);
    send_cmd(CMD_REVERSE, 8'd0, 32'h0000_0000);
    send_cmd(CMD_INSERT, 8'd1, 32'h8000_0000);
    send_cmd(CMD_INSERT, 8'd0, 32'h0000_0000);
    send_cmd(CMD_INSERT, 8'd1, 32'hffff_ffff);
    send_cmd(CMD_INSERT, 8'd255, 32'h5555_5555);
    // reads in and out of range
    send_cmd(CMD_READ, 8'd0, 32'haaaa_aaaa);
    send_cmd(CMD_READ, 8'd3, 32'h0000_0000);
    send_cmd(CMD_READ, 8'd4, 32'h0000_0000);
    send_cmd(CMD_READ, 8'd255, 32'h0000_0000);
    send_cmd(CMD_REVERSE, 8'd0, 32'h0000_0000);
    send_cmd(CMD_READ, 8'd0, 32'h0000_0000);
    // missing key, a hit, and a duplicate where only the first one goes
    send_cmd(CMD_DELETE, 8'd0, 32'h1234_5678);
    send_cmd(CMD_DELETE, 8'd0, 32'h8000_0000);
    send_cmd(CMD_INSERT, 8'd0, 32'hffff_ffff);
    send_cmd(CMD_INSERT, 8'd3, 32'haaaa_aaaa);
    send_cmd(CMD_DELETE, 8'd255, 32'hffff_ffff);
    send_cmd(CMD_READ, 8'd0, 32'h0000_0000);
    send_cmd(CMD_READ, 8'd1, 32'h0000_0000);
    send_cmd(CMD_REVERSE, 8'd0, 32'h0000_0000);
    drain();

    // random blocks with a drift up or down, two runs to a full array
    while (sent < 24 + RANDOM_ITEMS) begin
      if ((fills_done == 0 && sent >= 250) || (fills_done == 1 && sent >= 850)) begin
        fill_up();
        fills_done++;
        repeat ($urandom_range(60, 120)) random_cmd(MIX_SHRINK);
      end
      if (!paused && sent >= 600) begin
        drain();
        paused = 1'b1;
      end
      mix       = cmd_mix_e'($urandom_range(0, 2));
      block_len = $urandom_range(10, 60);
      repeat (block_len) random_cmd(mix);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("%0d commands sent, %0d results checked; fill level peaked at %0d of %0d",
             sent, checked, peak_fill, DEPTH_DEF);
    $display("inserts into a full array: %0d", full_hits);
    if (fail_count == 0) begin
      $display("ordered_array_table_engine test passed");
    end else begin
      $display("ordered_array_table_engine test failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin : watchdog
    #6ms;
    $display("ordered_array_table_engine test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/oate_pkg.sv
sv/oate_ram.sv
sv/oate_dp.sv
sv/oate_ctrl.sv
sv/ordered_array_table_engine.sv
tb/oate_table_checker.sv
tb/tb.sv
